/* rtl/wrf_pkg.sv */
// shared types, tags and constants for the wav/rf64 header parser
package wrf_pkg;

    localparam int POS_W = 48;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_RF64 = 32'h3436_4652;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DS64 = 32'h3436_7364;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_BEXT = 32'h7478_6562;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] LEN_FROM_DS64 = 32'hffff_ffff;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hfffe;
    localparam logic [15:0] FMT_PCM = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;
    localparam logic [15:0] BITS_PCM = 16'd24;
    localparam logic [15:0] BITS_FLOAT = 16'd32;
    localparam int TREF_START = 338;
    localparam int BEXT_END = 346;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_HEAD   = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_REJECT = 2'd3;

    localparam int FL_RF64   = 0;
    localparam int FL_FORMAT = 1;
    localparam int FL_DATA   = 2;
    localparam int FL_UNSUP  = 3;
    localparam int FL_BEXT   = 4;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_NOT_WAV  = 3'd1;
    localparam logic [2:0] ERR_UNSUP    = 3'd2;
    localparam logic [2:0] ERR_NO_DATA  = 3'd3;
    localparam logic [2:0] ERR_NO_FMT   = 3'd4;
    localparam logic [2:0] ERR_BAD_BLK  = 3'd5;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       is_last;
    } wrf_item_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic        is_rf64;
        logic        is_float;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic        has_bext;
        logic [63:0] time_reference;
        logic [47:0] data_offset;
        logic [47:0] data_bytes;
        logic [47:0] frame_count;
        logic [47:0] declared_end;
    } wrf_result_t;

    typedef struct packed {
        logic             header_ok;
        logic [4:0]       flags;
        logic [POS_W-1:0] file_len;
        logic [31:0]      riff_length;
        logic [63:0]      ds64_riff_size;
        logic [15:0]      format_tag;
        logic [15:0]      block_align;
        logic [15:0]      channel_count;
        logic [15:0]      sample_bits;
        logic [31:0]      sample_rate;
        logic [63:0]      time_reference;
        logic [POS_W-1:0] data_offset;
        logic [63:0]      data_size_raw;
    } wrf_state_t;

endpackage

/* rtl/wrf_div.sv */
// restoring divider, one quotient bit per cycle
module wrf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;

    assign trial = {rem_reg, quo_reg[47]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd48;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= 16'(trial - {1'b0, div_reg});
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/wrf_parse.sv */
// byte-serial header and chunk walker, fields gathered through byte shift registers
module wrf_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  wrf_pkg::wrf_item_t  item,
    input  logic                clear,
    output wrf_pkg::wrf_state_t st
);

    localparam int PW = wrf_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next, ncp_reg, ncp_next, bs_reg, bs_next;
    logic [PW-1:0] doff_reg, doff_next;
    logic [31:0]   tag_reg, tag_next, len_reg, len_next, riff_reg, riff_next;
    logic [1:0]    phase_reg, phase_next;
    logic [4:0]    flags_reg, flags_next;
    logic [63:0]   r64_reg, r64_next, d64_reg, d64_next, raw_reg, raw_next;
    logic [63:0]   ga_reg, ga_next, gb_reg, gb_next, tref_reg, tref_next;
    logic [15:0]   ftag_reg, ftag_next, align_reg, align_next;
    logic [15:0]   chan_reg, chan_next, bits_reg, bits_next;
    logic [31:0]   rate_reg, rate_next;
    logic [15:0]   stag_reg, stag_next, sch_reg, sch_next, salign_reg, salign_next;
    logic [15:0]   sbits_reg, sbits_next, ssub_reg, ssub_next;
    logic [31:0]   srate_reg, srate_next;

    logic [7:0]    b;
    logic [PW-1:0] hoff, boff;
    logic [8:0]    k;
    logic [5:0]    lim;
    logic [63:0]   size;
    logic [PW-1:0] size_c, s1_sat;
    logic [PW:0]   s1, bsum;
    logic [15:0]   tag_res;

    always_comb
    begin
        pos_next = pos_reg; ncp_next = ncp_reg; bs_next = bs_reg; doff_next = doff_reg;
        tag_next = tag_reg; len_next = len_reg; riff_next = riff_reg;
        phase_next = phase_reg; flags_next = flags_reg;
        r64_next = r64_reg; d64_next = d64_reg; raw_next = raw_reg;
        ga_next = ga_reg; gb_next = gb_reg; tref_next = tref_reg;
        ftag_next = ftag_reg; align_next = align_reg; chan_next = chan_reg;
        bits_next = bits_reg; rate_next = rate_reg;
        stag_next = stag_reg; sch_next = sch_reg; salign_next = salign_reg;
        sbits_next = sbits_reg; ssub_next = ssub_reg; srate_next = srate_reg;

        b = item.file_byte;
        hoff = pos_reg + PW'(8) - bs_reg;
        boff = pos_reg - bs_reg;
        k = boff[8:0];
        lim = (len_reg < 32'd40) ? len_reg[5:0] : 6'd40;
        size = '0; size_c = '0; s1 = '0; s1_sat = '0; tag_res = '0;
        bsum = {1'b0, pos_reg} + (PW+1)'(8);

        case (phase_reg)
            wrf_pkg::PH_HEADER:
            begin
                if (pos_reg < PW'(4))
                    tag_next = {b, tag_reg[31:8]};
                else if (pos_reg < PW'(8))
                    riff_next = {b, riff_reg[31:8]};
                else if (pos_reg < PW'(12))
                    ga_next = {b, ga_reg[63:8]};
                if (pos_reg >= PW'(11))
                begin
                    if ((tag_reg == wrf_pkg::TAG_RIFF || tag_reg == wrf_pkg::TAG_RF64)
                        && ga_next[63:32] == wrf_pkg::TAG_WAVE)
                    begin
                        if (tag_reg == wrf_pkg::TAG_RF64)
                            flags_next[wrf_pkg::FL_RF64] = 1'b1;
                        phase_next = wrf_pkg::PH_BODY;
                    end
                    else
                    begin
                        phase_next = wrf_pkg::PH_REJECT;
                    end
                    tag_next = '0;
                    len_next = '0;
                    ga_next = '0;
                end
            end
            wrf_pkg::PH_REJECT:
            begin
            end
            default:
            begin
                if (pos_reg == ncp_reg)
                begin
                    tag_next = {b, 24'd0};
                    len_next = '0;
                    bs_next = bsum[PW] ? wrf_pkg::POS_MAX : bsum[PW-1:0];
                    phase_next = wrf_pkg::PH_HEAD;
                end
                else if (phase_reg == wrf_pkg::PH_HEAD)
                begin
                    if (hoff < PW'(4))
                        tag_next = {b, tag_reg[31:8]};
                    else if (hoff < PW'(8))
                        len_next = {b, len_reg[31:8]};
                    if (hoff == PW'(7))
                    begin
                        // chunk header complete: work out where the next one starts
                        if (flags_reg[wrf_pkg::FL_RF64] && len_next == wrf_pkg::LEN_FROM_DS64)
                            size = d64_reg;
                        else
                            size = {32'd0, len_next};
                        if (tag_reg == wrf_pkg::TAG_DATA)
                        begin
                            raw_next = size;
                            doff_next = bs_reg;
                            flags_next[wrf_pkg::FL_DATA] = 1'b1;
                        end
                        size_c = (size > 64'(wrf_pkg::POS_MAX)) ? wrf_pkg::POS_MAX
                                                                : size[PW-1:0];
                        s1 = {1'b0, bs_reg} + {1'b0, size_c};
                        s1_sat = s1[PW] ? wrf_pkg::POS_MAX : s1[PW-1:0];
                        ncp_next = (s1_sat == wrf_pkg::POS_MAX) ? wrf_pkg::POS_MAX
                                 : s1_sat + PW'(size[0]);
                        phase_next = wrf_pkg::PH_BODY;
                    end
                end
                else if (pos_reg >= bs_reg && boff < PW'(wrf_pkg::BEXT_END))
                begin
                    if (tag_reg == wrf_pkg::TAG_DS64)
                    begin
                        if (k < 9'd8)
                            ga_next = {b, ga_reg[63:8]};
                        else if (k < 9'd16)
                            gb_next = {b, gb_reg[63:8]};
                        if (k == 9'd15 && len_reg >= 32'd16)
                        begin
                            r64_next = ga_next;
                            d64_next = gb_next;
                        end
                    end
                    else if (tag_reg == wrf_pkg::TAG_FMT)
                    begin
                        if (k < 9'd2)
                            stag_next = {b, stag_reg[15:8]};
                        else if (k < 9'd4)
                            sch_next = {b, sch_reg[15:8]};
                        else if (k < 9'd8)
                            srate_next = {b, srate_reg[31:8]};
                        else if (k == 9'd12 || k == 9'd13)
                            salign_next = {b, salign_reg[15:8]};
                        else if (k == 9'd14 || k == 9'd15)
                            sbits_next = {b, sbits_reg[15:8]};
                        else if (k == 9'd24 || k == 9'd25)
                            ssub_next = {b, ssub_reg[15:8]};
                        if (lim >= 6'd16 && k == {3'd0, lim - 6'd1})
                        begin
                            tag_res = (stag_next == wrf_pkg::FMT_EXTENSIBLE && lim >= 6'd26)
                                    ? ssub_next : stag_next;
                            ftag_next = tag_res;
                            chan_next = sch_next;
                            rate_next = srate_next;
                            align_next = salign_next;
                            bits_next = sbits_next;
                            if ((tag_res == wrf_pkg::FMT_PCM && sbits_next == wrf_pkg::BITS_PCM)
                                || (tag_res == wrf_pkg::FMT_FLOAT
                                    && sbits_next == wrf_pkg::BITS_FLOAT))
                                flags_next[wrf_pkg::FL_FORMAT] = 1'b1;
                            else
                            begin
                                flags_next[wrf_pkg::FL_FORMAT] = 1'b0;
                                flags_next[wrf_pkg::FL_UNSUP] = 1'b1;
                            end
                        end
                    end
                    else if (tag_reg == wrf_pkg::TAG_BEXT)
                    begin
                        if (k >= 9'(wrf_pkg::TREF_START))
                            ga_next = {b, ga_reg[63:8]};
                        if (k == 9'(wrf_pkg::BEXT_END - 1) && len_reg >= 32'(wrf_pkg::BEXT_END))
                        begin
                            tref_next = ga_next;
                            flags_next[wrf_pkg::FL_BEXT] = 1'b1;
                        end
                    end
                end
            end
        endcase

        pos_next = (pos_reg == wrf_pkg::POS_MAX) ? pos_reg : pos_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; ncp_reg <= PW'(12); bs_reg <= '0; doff_reg <= '0;
            tag_reg <= '0; len_reg <= '0; riff_reg <= '0;
            phase_reg <= wrf_pkg::PH_HEADER; flags_reg <= '0;
            r64_reg <= '0; d64_reg <= '0; raw_reg <= '0;
            ga_reg <= '0; gb_reg <= '0; tref_reg <= '0;
            ftag_reg <= '0; align_reg <= '0; chan_reg <= '0; bits_reg <= '0; rate_reg <= '0;
            stag_reg <= '0; sch_reg <= '0; salign_reg <= '0; sbits_reg <= '0;
            ssub_reg <= '0; srate_reg <= '0;
        end
        else if (clear)
        begin
            pos_reg <= '0; ncp_reg <= PW'(12); bs_reg <= '0; doff_reg <= '0;
            tag_reg <= '0; len_reg <= '0; riff_reg <= '0;
            phase_reg <= wrf_pkg::PH_HEADER; flags_reg <= '0;
            r64_reg <= '0; d64_reg <= '0; raw_reg <= '0;
            ga_reg <= '0; gb_reg <= '0; tref_reg <= '0;
            ftag_reg <= '0; align_reg <= '0; chan_reg <= '0; bits_reg <= '0; rate_reg <= '0;
            stag_reg <= '0; sch_reg <= '0; salign_reg <= '0; sbits_reg <= '0;
            ssub_reg <= '0; srate_reg <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_next; ncp_reg <= ncp_next; bs_reg <= bs_next;
            doff_reg <= doff_next;
            tag_reg <= tag_next; len_reg <= len_next; riff_reg <= riff_next;
            phase_reg <= phase_next; flags_reg <= flags_next;
            r64_reg <= r64_next; d64_reg <= d64_next; raw_reg <= raw_next;
            ga_reg <= ga_next; gb_reg <= gb_next; tref_reg <= tref_next;
            ftag_reg <= ftag_next; align_reg <= align_next; chan_reg <= chan_next;
            bits_reg <= bits_next; rate_reg <= rate_next;
            stag_reg <= stag_next; sch_reg <= sch_next; salign_reg <= salign_next;
            sbits_reg <= sbits_next; ssub_reg <= ssub_next; srate_reg <= srate_next;
        end
    end

    always_comb
    begin
        st.header_ok = (phase_reg == wrf_pkg::PH_HEAD) || (phase_reg == wrf_pkg::PH_BODY);
        st.flags = flags_reg;
        st.file_len = pos_reg;
        st.riff_length = riff_reg;
        st.ds64_riff_size = r64_reg;
        st.format_tag = ftag_reg;
        st.block_align = align_reg;
        st.channel_count = chan_reg;
        st.sample_bits = bits_reg;
        st.sample_rate = rate_reg;
        st.time_reference = tref_reg;
        st.data_offset = doff_reg;
        st.data_size_raw = raw_reg;
    end

endmodule

/* rtl/wav_rf64_header_parser_top.sv */
// wav/rf64 header parser top level: byte intake, end-of-file summary and frame division
// One file byte is taken per cycle while a file is being walked. After the beat marked
// is_last the block stalls its input for the summary: the CALC state sizes the data,
// the CHECK state checks the format, then, when no error is found, the bit-serial frame
// divider runs, then the result beat follows, which is held until taken.
module wav_rf64_header_parser_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  wrf_pkg::wrf_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output wrf_pkg::wrf_result_t result
);

    localparam int PW = wrf_pkg::POS_W;
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        take, clear, div_start, div_done;
    logic [47:0] quotient;
    wrf_pkg::wrf_state_t st;
    wrf_pkg::wrf_result_t res_reg, res_next;
    logic [PW-1:0] declared_reg, declared_next, dbytes_reg, dbytes_next;
    logic [31:0]   prod_reg;
    logic [PW-1:0] room, r64_c;
    logic [PW:0]   dsum;
    logic [2:0]    err;

    assign take = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign result = res_reg;
    assign clear = (state_reg == ST_OUT) && !result_stall;

    wrf_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .clear (clear),
        .st    (st)
    );

    wrf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (48'(dbytes_reg)),
        .divisor  (st.block_align),
        .done     (div_done),
        .quotient (quotient)
    );

    // sizes: declared end and data bytes clamped to the file
    always_comb
    begin
        r64_c = (st.ds64_riff_size > 64'(wrf_pkg::POS_MAX)) ? wrf_pkg::POS_MAX
                                                           : st.ds64_riff_size[PW-1:0];
        if (st.flags[wrf_pkg::FL_RF64])
            dsum = {1'b0, r64_c} + (PW+1)'(8);
        else
            dsum = (PW+1)'(st.riff_length) + (PW+1)'(8);
        declared_next = dsum[PW] ? wrf_pkg::POS_MAX : dsum[PW-1:0];
        room = (st.file_len > st.data_offset) ? st.file_len - st.data_offset : '0;
        if (!st.flags[wrf_pkg::FL_DATA])
            dbytes_next = '0;
        else if (st.data_size_raw < 64'(room))
            dbytes_next = PW'(st.data_size_raw);
        else
            dbytes_next = room;
    end

    always_comb
    begin
        if (!st.flags[wrf_pkg::FL_FORMAT] || !st.flags[wrf_pkg::FL_DATA])
        begin
            if (st.flags[wrf_pkg::FL_UNSUP])
                err = wrf_pkg::ERR_UNSUP;
            else if (st.flags[wrf_pkg::FL_FORMAT])
                err = wrf_pkg::ERR_NO_DATA;
            else
                err = wrf_pkg::ERR_NO_FMT;
        end
        else if (st.block_align == 16'd0 || {13'd0, st.block_align} != prod_reg[31:3])
            err = wrf_pkg::ERR_BAD_BLK;
        else
            err = wrf_pkg::ERR_OK;
    end

    always_comb
    begin
        state_next = state_reg;
        res_next = res_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && item.is_last)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                res_next = '0;
                if (!st.header_ok)
                begin
                    res_next.error_code = wrf_pkg::ERR_NOT_WAV;
                    state_next = ST_OUT;
                end
                else
                begin
                    res_next.error_code = err;
                    res_next.is_rf64 = st.flags[wrf_pkg::FL_RF64];
                    res_next.is_float = (st.format_tag == wrf_pkg::FMT_FLOAT);
                    res_next.channel_count = st.channel_count;
                    res_next.sample_rate = st.sample_rate;
                    res_next.sample_bits = st.sample_bits;
                    res_next.has_bext = st.flags[wrf_pkg::FL_BEXT];
                    res_next.time_reference = st.time_reference;
                    res_next.data_offset = st.flags[wrf_pkg::FL_DATA] ? 48'(st.data_offset)
                                                                      : 48'd0;
                    res_next.data_bytes = 48'(dbytes_reg);
                    res_next.declared_end = 48'(declared_reg);
                    if (err == wrf_pkg::ERR_OK)
                    begin
                        div_start = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next.frame_count = quotient;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == ST_CALC)
        begin
            declared_reg <= declared_next;
            dbytes_reg <= dbytes_next;
            prod_reg <= st.channel_count * st.sample_bits;
        end
    end

endmodule
